>>> rtl/pkss_pkg.sv
// Package: shared types and constants for the per-key statistics block.
package pkss_pkg;

  localparam int KeyW   = 120;
  localparam int CountW = 24;
  localparam int SumW   = 40;
  localparam int SqW    = 56;
  localparam int EnergyW = 48;
  localparam int CntW   = 32;

  localparam logic [1:0] KIND_TEMP   = 2'd0;
  localparam logic [1:0] KIND_ENERGY = 2'd1;

  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  typedef struct packed {
    logic        action;
    logic [55:0] key_high;
    logic [63:0] key_low;
    logic [1:0]  kind;
    logic        alert;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic        anomaly;
    logic        sensor_found;
    logic        table_full_drop;
    logic [31:0] alert_total;
    logic signed [47:0] energy_total;
    logic [31:0] anomaly_total;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_READ, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5,
    ST_CMP, ST_DONE
  } back_state_t;

endpackage

>>> rtl/per_key_stats_sigma_outlier.sv
// Top level: per-key temperature statistics with k-sigma outlier check.
//  channel | handshake          | payload
//  input   | push / full        | in_item  (in_item_t)
//  result  | pop / empty        | out_item (out_item_t)
//  config  | sigma_we           | sigma_wdata (4 bits)
// An accumulate or non-temperature item passes through SEARCH, READ and DONE in the
// back end; a temperature check on a stored key also runs the registered multiply chain.
// Key match is one registered compare over all stored keys.
// rst is synchronous; counters and table fill clear, table contents do not.
// A two-deep input queue and one result register let either side stall.
module per_key_stats_sigma_outlier import pkss_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item,
  input  logic      sigma_we,
  input  logic [3:0] sigma_wdata
);
  in_item_t q_item;
  logic q_valid, q_take, res_valid;
  logic [3:0] sigma_k;

  always_ff @(posedge clk) begin
    if (rst) sigma_k <= 4'd3;
    else if (sigma_we) sigma_k <= sigma_wdata;
  end

  pkss_front u_front (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .q_item(q_item), .q_valid(q_valid), .q_take(q_take));

  pkss_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .sigma_k(sigma_k), .q_item(q_item),
    .q_valid(q_valid), .q_take(q_take), .res(out_item),
    .res_valid(res_valid), .res_take(pop));

  assign empty = !res_valid;
endmodule

>>> rtl/pkss_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module pkss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/pkss_front.sv
// Front end: input queue; the global counters (alerts, energy) live in the back end.
module pkss_front import pkss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_item,
  input  logic     push,
  output logic     full,
  output in_item_t q_item,
  output logic     q_valid,
  input  logic     q_take
);
  // two-entry queue decouples acceptance from the back end
  in_item_t    buf_item [2];
  logic        wptr, rptr;
  logic [1:0]  fill;
  logic        do_push, do_pop;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_item  = buf_item[rptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_item[wptr] <= in_item;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

>>> rtl/pkss_back.sv
// Back end: key search, statistics update and sigma check, result register.
module pkss_back import pkss_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic [3:0] sigma_k,
  input  in_item_t  q_item,
  input  logic      q_valid,
  output logic      q_take,
  output out_item_t res,
  output logic      res_valid,
  input  logic      res_take
);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = $clog2(TABLE_DEPTH + 1);

  back_state_t state, state_next;
  in_item_t    cur;
  logic [UW-1:0] used;
  logic [IW-1:0] hit_idx;
  logic        hit;
  logic [CntW-1:0] alert_cnt, anom_cnt;
  logic signed [EnergyW-1:0] energy;
  logic        anom_r, found_r, drop_r;

  // key store in flops for parallel match (valid by fill count)
  logic [KeyW-1:0] keys [TABLE_DEPTH];

  // stats RAMs
  logic              st_we;
  logic [IW-1:0]     st_addr;
  logic [CountW-1:0] cnt_wd, cnt_rd;
  logic [SumW-1:0]   sum_wd, sum_rd;
  logic [SqW-1:0]    sq_wd, sq_rd;

  pkss_ram #(.WIDTH(CountW), .DEPTH(TABLE_DEPTH)) u_cnt (
    .clk(clk), .we(st_we), .waddr(st_addr), .wdata(cnt_wd), .raddr(st_addr),
    .rdata(cnt_rd));
  pkss_ram #(.WIDTH(SumW), .DEPTH(TABLE_DEPTH)) u_sum (
    .clk(clk), .we(st_we), .waddr(st_addr), .wdata(sum_wd), .raddr(st_addr),
    .rdata(sum_rd));
  pkss_ram #(.WIDTH(SqW), .DEPTH(TABLE_DEPTH)) u_sq (
    .clk(clk), .we(st_we), .waddr(st_addr), .wdata(sq_wd), .raddr(st_addr),
    .rdata(sq_rd));

  // parallel match, registered hit
  logic          m_hit;
  logic [IW-1:0] m_idx;
  always_comb begin
    m_hit = 1'b0;
    m_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if ((UW'(i) < used) && keys[i] == {cur.key_high, cur.key_low} && !m_hit) begin
        m_hit = 1'b1;
        m_idx = IW'(i);
      end
    end
  end

  logic is_temp, is_new, tbl_full, cnt_sat;
  assign is_temp  = (cur.kind == KIND_TEMP);
  assign tbl_full = (used == UW'(TABLE_DEPTH));
  assign is_new   = !hit && !tbl_full;
  assign cnt_sat  = (cnt_rd == {CountW{1'b1}});

  // check datapath: registered partial products
  logic [CountW-1:0] n_r;
  logic signed [SumW-1:0] s_r;
  logic [SqW-1:0] q_r;
  logic [SumW-1:0] s_mag;
  logic [81:0] nq;       // n*Q  (24+56 bits)
  logic [79:0] s2;       // S^2
  logic signed [42:0] d; // n*v - S
  logic [41:0] d_mag;
  logic [83:0] lhs;
  logic [80:0] var_r;
  logic [88:0] rhs;
  logic        var_pos;
  logic [7:0]  kk;
  logic [CntW-1:0] add_a;
  logic signed [EnergyW:0] e_sum;
  // wide products are split in halves, computed in consecutive MUL states
  logic [27:0] q_half;
  logic [19:0] s_half;
  logic [20:0] d_half;
  logic [51:0] nq_pp;
  logic [59:0] s2_pp;
  logic [62:0] lhs_pp;

  assign s_mag = s_r[SumW-1] ? SumW'(-s_r) : SumW'(s_r);
  assign kk    = sigma_k * sigma_k;
  assign e_sum = {energy[EnergyW-1], energy} + (EnergyW+1)'(cur.value);

  assign q_half = (state == ST_MUL2) ? q_r[27:0] : q_r[55:28];
  assign s_half = (state == ST_MUL2) ? s_mag[19:0] : s_mag[39:20];
  assign d_half = (state == ST_MUL4) ? d_mag[20:0] : d_mag[41:21];
  assign nq_pp  = 52'(n_r) * 52'(q_half);
  assign s2_pp  = 60'(s_mag) * 60'(s_half);
  assign lhs_pp = 63'(d_mag) * 63'(d_half);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_valid && !res_valid) state_next = ST_SEARCH;
      ST_SEARCH: state_next = ST_READ;
      ST_READ: begin
        if (cur.action == ACT_CHECK && is_temp && hit) state_next = ST_MUL1;
        else state_next = ST_DONE;
      end
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_MUL3;
      ST_MUL3:   state_next = ST_MUL4;
      ST_MUL4:   state_next = ST_MUL5;
      ST_MUL5:   state_next = ST_CMP;
      ST_CMP:    state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_take  = (state == ST_IDLE) && q_valid && !res_valid;
    st_we   = 1'b0;
    // stats read starts from the live match so the data is ready in READ
    st_addr = (state == ST_SEARCH) ? m_idx : hit_idx;
    cnt_wd  = cnt_rd + CountW'(1);
    sum_wd  = sum_rd + SumW'(cur.value);
    sq_wd   = sq_rd + SqW'(32'($signed(cur.value) * $signed(cur.value)));
    if (state == ST_READ && cur.action == ACT_ACCUM && is_temp && is_new) begin
      // fresh entry: write the first sample directly
      st_we  = 1'b1;
      st_addr = IW'(used);
      cnt_wd = CountW'(1);
      sum_wd = SumW'(cur.value);
      sq_wd  = SqW'(32'($signed(cur.value) * $signed(cur.value)));
    end else if (state == ST_READ && cur.action == ACT_ACCUM && is_temp && hit &&
                 !cnt_sat) begin
      st_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_take) cur <= q_item;
    if (state == ST_SEARCH) begin
      hit     <= m_hit;
      hit_idx <= m_idx;
    end
    if (state == ST_READ && cur.action == ACT_ACCUM && is_temp && is_new)
      keys[IW'(used)] <= {cur.key_high, cur.key_low};
    if (state == ST_MUL1) begin
      n_r <= cnt_rd;
      s_r <= sum_rd;
      q_r <= sq_rd;
    end
    if (state == ST_MUL2) begin
      nq <= 82'(nq_pp);
      s2 <= 80'(s2_pp);
      d  <= $signed({1'b0, n_r}) * 43'(cur.value) - 43'(s_r);
    end
    if (state == ST_MUL3) begin
      nq    <= nq + (82'(nq_pp) << 28);
      s2    <= s2 + (80'(s2_pp) << 20);
      d_mag <= d[42] ? 42'(-d) : 42'(d);
    end
    if (state == ST_MUL4) begin
      var_pos <= nq > 82'(s2);
      var_r   <= 81'(nq - 82'(s2));
      lhs     <= 84'(lhs_pp);
    end
    if (state == ST_MUL5) begin
      lhs <= lhs + (84'(lhs_pp) << 21);
      rhs <= 89'(var_r) * 89'(kk);
    end
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      res_valid <= 1'b0;
      alert_cnt <= '0;
      anom_cnt  <= '0;
      energy    <= '0;
      anom_r    <= 1'b0;
      found_r   <= 1'b0;
      drop_r    <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res_take) res_valid <= 1'b0;
      if (state == ST_READ) begin
        anom_r  <= 1'b0;
        found_r <= is_temp && (hit || (cur.action == ACT_ACCUM && !tbl_full));
        drop_r  <= is_temp && cur.action == ACT_ACCUM && !hit && tbl_full;
        if (cur.action == ACT_ACCUM) begin
          if (is_temp && is_new) used <= used + UW'(1);
          if (cur.alert && alert_cnt != {CntW{1'b1}}) alert_cnt <= alert_cnt + CntW'(1);
          if (cur.kind == KIND_ENERGY) begin
            if (e_sum[EnergyW] != e_sum[EnergyW-1])
              energy <= e_sum[EnergyW] ? {1'b1, {(EnergyW-1){1'b0}}}
                                       : {1'b0, {(EnergyW-1){1'b1}}};
            else energy <= e_sum[EnergyW-1:0];
          end
        end
      end
      if (state == ST_CMP && var_pos && 89'(lhs) > rhs) begin
        anom_r <= 1'b1;
        if (anom_cnt != {CntW{1'b1}}) anom_cnt <= anom_cnt + CntW'(1);
      end
      if (state == ST_DONE) res_valid <= 1'b1;
    end
  end

  assign add_a = anom_cnt;
  always_comb begin
    res.anomaly         = anom_r;
    res.sensor_found    = found_r;
    res.table_full_drop = drop_r;
    res.alert_total     = alert_cnt;
    res.energy_total    = energy;
    res.anomaly_total   = add_a;
  end
endmodule

>>> rtl/pkss_checker.sv
// Checker: port-level assertions, bound to the top level.
module pkss_checker import pkss_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);
  a_pop_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item))) else $error("result lost");
  // alert total only counts up
  a_alert_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> out_item.alert_total >= $past(out_item.alert_total))
    else $error("alert total");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(out_item.sensor_found && out_item.table_full_drop))
    else $error("found and dropped");
  a_anom: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.anomaly) |-> out_item.sensor_found) else $error("anomaly w/o key");
  a_reset: assert property (@(posedge clk) rst |=> (empty && !full)) else $error("reset");
endmodule

bind per_key_stats_sigma_outlier pkss_checker u_chk (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop),
  .out_item(out_item));
